// ===== rtl/core/adaptive_cruise_accel_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Adaptive cruise acceleration controller: assertion macros
// Shorthand for the concurrent checks of the controller, clocked on clk and
// held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_CRUISE_ACCEL_CONTROLLER_DEFINES_SVH
`define ADAPTIVE_CRUISE_ACCEL_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define ACAC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acac: same-cycle check failed");

// next-cycle implication
`define ACAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acac: next-cycle check failed");

`endif

// ===== rtl/core/acac_pkg.sv =====
// ----------------------------------------------------------------------------
// acac_pkg
// Widths, register codes, reset values and word types shared by the
// adaptive cruise acceleration controller.
// ----------------------------------------------------------------------------
package acac_pkg;

	localparam int GAP_W      = 16;
	localparam int SPEED_W    = 14;
	localparam int ACCEL_W    = 13;
	localparam int TTC_W      = 13;
	localparam int GAIN_W     = 8;
	localparam int SGAIN_W    = 9;
	localparam int LIMIT_W    = 12;
	localparam int DEADBAND_W = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int FRAC_W     = 8;

	localparam int CLOSING_W  = SPEED_W + 1;
	localparam int ERR_W      = GAP_W + 1;
	localparam int SUM_W      = 26;
	localparam int CMD_W      = SUM_W - FRAC_W;
	localparam int NUM_W      = GAP_W + FRAC_W;
	localparam int DIV_STEPS  = NUM_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam int DELAY_TICKS_DEF = 3;

	localparam logic [NUM_W-1:0]  TTC_MAX_Q8  = NUM_W'(5120);
	localparam logic [SUM_W-1:0]  ROUND_HALF  = SUM_W'(128);

	localparam logic [GAP_W-1:0]        RST_GAP_SETPOINT = 16'd10240;
	localparam logic [GAIN_W-1:0]       RST_GAP_GAIN     = 8'd38;
	localparam logic [SGAIN_W-1:0]      RST_SPEED_GAIN   = 9'd205;
	localparam logic [LIMIT_W-1:0]      RST_ACCEL_LIMIT  = 12'd768;
	localparam logic [ACCEL_W-1:0]      RST_BRAKE_LIMIT  = 13'h1800;
	localparam logic [LIMIT_W-1:0]      RST_JERK_STEP    = 12'd384;
	localparam logic [TTC_W-1:0]        RST_TTC_LIMIT    = 13'd512;
	localparam logic [DEADBAND_W-1:0]   RST_DEADBAND     = 11'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAP_SETPOINT = 3'd0,
		CFG_GAP_GAIN     = 3'd1,
		CFG_SPEED_GAIN   = 3'd2,
		CFG_ACCEL_LIMIT  = 3'd3,
		CFG_BRAKE_LIMIT  = 3'd4,
		CFG_JERK_STEP    = 3'd5,
		CFG_TTC_LIMIT    = 3'd6,
		CFG_DEADBAND     = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_CLAMP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [GAP_W-1:0]   gap_distance;
		logic [SPEED_W-1:0] ego_speed;
		logic [SPEED_W-1:0] lead_speed;
	} item_t;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_out;
		logic [TTC_W-1:0]          ttc_value;
		logic                      ttc_valid;
		logic                      emergency;
	} result_t;

	// control for the two bit-serial units
	typedef struct packed {
		logic              start;
		logic              step;
		logic [STEP_W-1:0] idx;
	} seq_ctl_t;

	// control for the limiter
	typedef struct packed {
		logic clamp;
		logic commit;
	} lim_ctl_t;

endpackage

// ===== rtl/core/acac_serial_mac.sv =====
// ----------------------------------------------------------------------------
// acac_serial_mac
// Bit-serial PD sum: gap_gain*err - speed_gain*closing + 128, one gain bit
// per cycle, gap gain bits first, then speed gain bits.
// ----------------------------------------------------------------------------
module acac_serial_mac (
	input  logic                                    clk,
	input  acac_pkg::seq_ctl_t                      ctl,
	input  logic signed [acac_pkg::ERR_W-1:0]       gap_err,
	input  logic signed [acac_pkg::CLOSING_W-1:0]   closing,
	input  logic [acac_pkg::GAIN_W-1:0]             gap_gain,
	input  logic [acac_pkg::SGAIN_W-1:0]            speed_gain,
	output logic signed [acac_pkg::SUM_W-1:0]       sum
);

	localparam int MB_W = acac_pkg::GAIN_W + acac_pkg::SGAIN_W;

	logic [MB_W-1:0]                         mb_q;
	logic signed [acac_pkg::SUM_W-1:0]       md_q;
	logic signed [acac_pkg::SUM_W-1:0]       acc_q;
	logic signed [acac_pkg::CLOSING_W-1:0]   nc_q;
	logic signed [acac_pkg::SUM_W-1:0]       addend;
	logic signed [acac_pkg::SUM_W-1:0]       nc_ext;

	assign addend = mb_q[0] ? md_q : '0;
	assign nc_ext = {{(acac_pkg::SUM_W-acac_pkg::CLOSING_W){nc_q[acac_pkg::CLOSING_W-1]}}, nc_q};
	assign sum    = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mb_q  <= {speed_gain, gap_gain};
			md_q  <= {{(acac_pkg::SUM_W-acac_pkg::ERR_W){gap_err[acac_pkg::ERR_W-1]}}, gap_err};
			nc_q  <= -closing;
			acc_q <= acac_pkg::ROUND_HALF;
		end else if (ctl.step) begin
			acc_q <= acc_q + addend;
			mb_q  <= mb_q >> 1;
			// after the last gap gain bit switch to the negated closing speed
			if (ctl.idx == acac_pkg::STEP_W'(acac_pkg::GAIN_W - 1)) begin
				md_q <= nc_ext;
			end else begin
				md_q <= md_q <<< 1;
			end
		end
	end

endmodule

// ===== rtl/core/acac_serial_div.sv =====
// ----------------------------------------------------------------------------
// acac_serial_div
// Restoring divider for gap*256 / closing, one quotient bit per cycle.
// Gives the full quotient and whether the remainder is zero.
// ----------------------------------------------------------------------------
module acac_serial_div (
	input  logic                                clk,
	input  acac_pkg::seq_ctl_t                  ctl,
	input  logic [acac_pkg::GAP_W-1:0]          gap,
	input  logic [acac_pkg::SPEED_W-1:0]        divisor,
	output logic [acac_pkg::NUM_W-1:0]          quot,
	output logic                                rem_zero
);

	logic [acac_pkg::NUM_W-1:0]   dsh_q;
	logic [acac_pkg::NUM_W-1:0]   quot_q;
	logic [acac_pkg::SPEED_W-1:0] dvs_q;
	logic [acac_pkg::SPEED_W-1:0] rem_q;
	logic [acac_pkg::SPEED_W:0]   trial;
	logic [acac_pkg::SPEED_W:0]   diff;
	logic                         fits;

	assign trial    = {rem_q, dsh_q[acac_pkg::NUM_W-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign diff     = trial - {1'b0, dvs_q};
	assign quot     = quot_q;
	assign rem_zero = rem_q == '0;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dsh_q  <= {gap, acac_pkg::FRAC_W'(0)};
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (ctl.step) begin
			dsh_q  <= dsh_q << 1;
			rem_q  <= fits ? diff[acac_pkg::SPEED_W-1:0] : trial[acac_pkg::SPEED_W-1:0];
			quot_q <= {quot_q[acac_pkg::NUM_W-2:0], fits};
		end
	end

endmodule

// ===== rtl/core/acac_limiter.sv =====
// ----------------------------------------------------------------------------
// acac_limiter
// Rounds and clamps the PD command, runs it through the command delay line
// and limits its change against the last acceleration.
// ----------------------------------------------------------------------------
module acac_limiter #(
	parameter int DELAY_TICKS = acac_pkg::DELAY_TICKS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  acac_pkg::lim_ctl_t                    ctl,
	input  logic signed [acac_pkg::SUM_W-1:0]     sum,
	input  logic                                  emergency,
	input  logic signed [acac_pkg::ACCEL_W-1:0]   brake_limit,
	input  logic [acac_pkg::LIMIT_W-1:0]          accel_limit,
	input  logic [acac_pkg::LIMIT_W-1:0]          jerk_step,
	output logic signed [acac_pkg::ACCEL_W-1:0]   accel
);

	localparam int CMD_W = acac_pkg::CMD_W;
	localparam int JRK_W = acac_pkg::ACCEL_W + 1;

	logic signed [CMD_W-1:0]             cmd;
	logic signed [CMD_W-1:0]             brk_ext;
	logic signed [CMD_W-1:0]             acl_ext;
	logic signed [CMD_W-1:0]             c_emer;
	logic signed [CMD_W-1:0]             c_low;
	logic signed [CMD_W-1:0]             c_high;
	logic signed [acac_pkg::ACCEL_W-1:0] cmd_q;
	logic signed [acac_pkg::ACCEL_W-1:0] delayed;
	logic signed [acac_pkg::ACCEL_W-1:0] last_q;
	logic signed [JRK_W-1:0]             lo;
	logic signed [JRK_W-1:0]             hi;
	logic signed [JRK_W-1:0]             d_ext;
	logic signed [JRK_W-1:0]             limited;

	// floor shift into signed Q10.8
	assign cmd     = sum[acac_pkg::SUM_W-1:acac_pkg::FRAC_W];
	assign brk_ext = {{(CMD_W-acac_pkg::ACCEL_W){brake_limit[acac_pkg::ACCEL_W-1]}}, brake_limit};
	assign acl_ext = {{(CMD_W-acac_pkg::LIMIT_W){1'b0}}, accel_limit};

	// brake floor first, accel ceiling last so it wins on crossed limits
	always_comb begin
		c_emer = emergency ? brk_ext : cmd;
		c_low  = (c_emer < brk_ext) ? brk_ext : c_emer;
		c_high = (c_low > acl_ext) ? acl_ext : c_low;
	end

	always_ff @(posedge clk) begin
		if (ctl.clamp) begin
			cmd_q <= c_high[acac_pkg::ACCEL_W-1:0];
		end
	end

	generate
		if (DELAY_TICKS == 0) begin : g_no_delay
			assign delayed = cmd_q;
		end else begin : g_delay
			logic signed [acac_pkg::ACCEL_W-1:0] line_q [DELAY_TICKS];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int i = 0; i < DELAY_TICKS; i++) begin
						line_q[i] <= '0;
					end
				end else if (ctl.commit) begin
					line_q[0] <= cmd_q;
					for (int i = 1; i < DELAY_TICKS; i++) begin
						line_q[i] <= line_q[i-1];
					end
				end
			end

			assign delayed = line_q[DELAY_TICKS-1];
		end
	endgenerate

	assign lo    = {last_q[acac_pkg::ACCEL_W-1], last_q} - {2'b00, jerk_step};
	assign hi    = {last_q[acac_pkg::ACCEL_W-1], last_q} + {2'b00, jerk_step};
	assign d_ext = {delayed[acac_pkg::ACCEL_W-1], delayed};

	always_comb begin
		if (d_ext < lo) begin
			limited = lo;
		end else if (d_ext > hi) begin
			limited = hi;
		end else begin
			limited = d_ext;
		end
	end

	// result lies between last and delayed, so it fits the output width
	assign accel = limited[acac_pkg::ACCEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (ctl.commit) begin
			last_q <= accel;
		end
	end

endmodule

// ===== rtl/core/adaptive_cruise_accel_controller.sv =====
// ----------------------------------------------------------------------------
// adaptive_cruise_accel_controller
// Per-tick acceleration command with PD gap control, TTC emergency braking,
// command delay and jerk limiting.
// ----------------------------------------------------------------------------
// One word per control tick passes from acceptance to the result register
// through the idle state that accepts it, the run state of the bit-serial
// divider (one quotient bit of gap*256/closing per cycle, the PD sum
// accumulating one gain bit per cycle beside it), a clamp state and a finish
// state that commits the delayed, jerk-limited command. item_stall is high in
// the run, clamp and finish states. The result sits in an output register, so
// the next word is taken while an earlier result still waits on result_stall;
// a finished word waits in the finish state until that register is free.
// Configuration writes take effect at once and belong between words.
// ----------------------------------------------------------------------------
`include "adaptive_cruise_accel_controller_defines.svh"

module adaptive_cruise_accel_controller #(
	parameter int DELAY_TICKS = acac_pkg::DELAY_TICKS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  acac_pkg::item_t                       item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output acac_pkg::result_t                     result,
	input  logic                                  cfg_write,
	input  logic [acac_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [acac_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam logic [acac_pkg::STEP_W-1:0] LAST_STEP = acac_pkg::STEP_W'(acac_pkg::DIV_STEPS - 1);

	// configuration
	logic [acac_pkg::GAP_W-1:0]          gap_setpoint_q;
	logic [acac_pkg::GAIN_W-1:0]         gap_gain_q;
	logic [acac_pkg::SGAIN_W-1:0]        speed_gain_q;
	logic [acac_pkg::LIMIT_W-1:0]        accel_limit_q;
	logic signed [acac_pkg::ACCEL_W-1:0] brake_limit_q;
	logic [acac_pkg::LIMIT_W-1:0]        jerk_step_q;
	logic [acac_pkg::TTC_W-1:0]          ttc_limit_q;
	logic [acac_pkg::DEADBAND_W-1:0]     deadband_q;

	acac_pkg::state_t                    state_q;
	acac_pkg::state_t                    state_d;
	logic [acac_pkg::STEP_W-1:0]         step_q;
	logic                                closing_gt_q;
	logic                                result_valid_q;
	acac_pkg::result_t                   result_q;

	acac_pkg::seq_ctl_t                  seq_ctl;
	acac_pkg::lim_ctl_t                  lim_ctl;
	logic                                accept;
	logic                                out_free;

	logic signed [acac_pkg::CLOSING_W-1:0] closing;
	logic signed [acac_pkg::ERR_W-1:0]     gap_err;
	logic signed [acac_pkg::SUM_W-1:0]     pd_sum;
	logic [acac_pkg::NUM_W-1:0]            quot;
	logic                                  rem_zero;
	logic                                  emer;
	logic                                  ttc_ok;
	logic signed [acac_pkg::ACCEL_W-1:0]   accel;

	assign accept   = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;

	assign closing = $signed({1'b0, item.ego_speed}) - $signed({1'b0, item.lead_speed});
	assign gap_err = $signed({1'b0, item.gap_distance}) - $signed({1'b0, gap_setpoint_q});

	// TTC compares done on the floored quotient
	assign emer   = closing_gt_q &&
		(quot < {{(acac_pkg::NUM_W-acac_pkg::TTC_W){1'b0}}, ttc_limit_q});
	assign ttc_ok = closing_gt_q && ((quot < acac_pkg::TTC_MAX_Q8) ||
		((quot == acac_pkg::TTC_MAX_Q8) && rem_zero));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_setpoint_q <= acac_pkg::RST_GAP_SETPOINT;
			gap_gain_q     <= acac_pkg::RST_GAP_GAIN;
			speed_gain_q   <= acac_pkg::RST_SPEED_GAIN;
			accel_limit_q  <= acac_pkg::RST_ACCEL_LIMIT;
			brake_limit_q  <= acac_pkg::RST_BRAKE_LIMIT;
			jerk_step_q    <= acac_pkg::RST_JERK_STEP;
			ttc_limit_q    <= acac_pkg::RST_TTC_LIMIT;
			deadband_q     <= acac_pkg::RST_DEADBAND;
		end else if (cfg_write) begin
			case (acac_pkg::cfg_idx_t'(cfg_index))
				acac_pkg::CFG_GAP_SETPOINT: gap_setpoint_q <= cfg_data[acac_pkg::GAP_W-1:0];
				acac_pkg::CFG_GAP_GAIN:     gap_gain_q     <= cfg_data[acac_pkg::GAIN_W-1:0];
				acac_pkg::CFG_SPEED_GAIN:   speed_gain_q   <= cfg_data[acac_pkg::SGAIN_W-1:0];
				acac_pkg::CFG_ACCEL_LIMIT:  accel_limit_q  <= cfg_data[acac_pkg::LIMIT_W-1:0];
				acac_pkg::CFG_BRAKE_LIMIT:  brake_limit_q  <= cfg_data[acac_pkg::ACCEL_W-1:0];
				acac_pkg::CFG_JERK_STEP:    jerk_step_q    <= cfg_data[acac_pkg::LIMIT_W-1:0];
				acac_pkg::CFG_TTC_LIMIT:    ttc_limit_q    <= cfg_data[acac_pkg::TTC_W-1:0];
				acac_pkg::CFG_DEADBAND:     deadband_q     <= cfg_data[acac_pkg::DEADBAND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acac_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (seq_ctl.step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			closing_gt_q <= closing > $signed({4'b0000, deadband_q});
		end
	end

	always_comb begin
		state_d        = state_q;
		item_stall     = 1'b1;
		seq_ctl.start  = 1'b0;
		seq_ctl.step   = 1'b0;
		seq_ctl.idx    = step_q;
		lim_ctl.clamp  = 1'b0;
		lim_ctl.commit = 1'b0;
		case (state_q)
			acac_pkg::ST_IDLE: begin
				item_stall    = 1'b0;
				seq_ctl.start = item_valid;
				if (item_valid) begin
					state_d = acac_pkg::ST_RUN;
				end
			end
			acac_pkg::ST_RUN: begin
				seq_ctl.step = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = acac_pkg::ST_CLAMP;
				end
			end
			acac_pkg::ST_CLAMP: begin
				lim_ctl.clamp = 1'b1;
				state_d       = acac_pkg::ST_FINISH;
			end
			acac_pkg::ST_FINISH: begin
				if (out_free) begin
					lim_ctl.commit = 1'b1;
					state_d        = acac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = acac_pkg::ST_IDLE;
			end
		endcase
	end

	acac_serial_mac u_mac (
		.clk        (clk),
		.ctl        (seq_ctl),
		.gap_err    (gap_err),
		.closing    (closing),
		.gap_gain   (gap_gain_q),
		.speed_gain (speed_gain_q),
		.sum        (pd_sum)
	);

	acac_serial_div u_div (
		.clk      (clk),
		.ctl      (seq_ctl),
		.gap      (item.gap_distance),
		.divisor  (closing[acac_pkg::SPEED_W-1:0]),
		.quot     (quot),
		.rem_zero (rem_zero)
	);

	acac_limiter #(
		.DELAY_TICKS (DELAY_TICKS)
	) u_limiter (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (lim_ctl),
		.sum         (pd_sum),
		.emergency   (emer),
		.brake_limit (brake_limit_q),
		.accel_limit (accel_limit_q),
		.jerk_step   (jerk_step_q),
		.accel       (accel)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (lim_ctl.commit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lim_ctl.commit) begin
			result_q.accel_out <= accel;
			result_q.ttc_value <= ttc_ok ? quot[acac_pkg::TTC_W-1:0] : '0;
			result_q.ttc_valid <= ttc_ok;
			result_q.emergency <= emer;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ACAC_ASSERT_NEXT(a_accept_starts_run, accept, state_q == acac_pkg::ST_RUN)
	`ACAC_ASSERT_NEXT(a_commit_shows_word, lim_ctl.commit, result_valid_q && (state_q == acac_pkg::ST_IDLE))
	`ACAC_ASSERT_IMPLY(a_ttc_zero_when_invalid, result_valid_q && !result_q.ttc_valid, result_q.ttc_value == '0)
	`ACAC_ASSERT_IMPLY(a_ttc_in_range, result_valid_q && result_q.ttc_valid, result_q.ttc_value <= acac_pkg::TTC_MAX_Q8[acac_pkg::TTC_W-1:0])

endmodule

// ===== verif/accel_command_checker.sv =====
// ----------------------------------------------------------------------------
// accel_command_checker
// Watches the word and register ports of the cruise controller, keeps its own
// copy of the registers, delay line and last command, predicts each result
// word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module accel_command_checker
	import acac_pkg::*;
#(
	parameter int DELAY_TICKS = DELAY_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_stall,
	input  item_t                 item,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  result_t               result,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding,
	output int                    checked
);

	localparam int PRINT_CAP = 100;

	logic [GAP_W-1:0]          setpoint_q;
	logic [GAIN_W-1:0]         gap_gain_q;
	logic [SGAIN_W-1:0]        speed_gain_q;
	logic [LIMIT_W-1:0]        accel_lim_q;
	logic signed [ACCEL_W-1:0] brake_lim_q;
	logic [LIMIT_W-1:0]        jerk_q;
	logic [TTC_W-1:0]          ttc_lim_q;
	logic [DEADBAND_W-1:0]     deadband_q;

	longint  cmd_line [DELAY_TICKS+1];
	int      line_pos;
	longint  last_accel;
	result_t expected_cmds [$];
	result_t want;
	result_t fresh;

	task automatic flag_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("mismatch at result %0d: %s", checked, msg);
		mismatches++;
	endtask

	// one control tick: PD command, TTC test, clamp, delay line, jerk limit
	task automatic predict_tick(input item_t w, output result_t r);
		longint gap, closing, err, brake, cmd, num, delayed, acc;
		int     p;
		logic   emer;
		gap     = longint'(w.gap_distance);
		closing = longint'(w.ego_speed) - longint'(w.lead_speed);
		err     = gap - longint'(setpoint_q);
		brake   = longint'(brake_lim_q);
		cmd     = (longint'(gap_gain_q) * err - longint'(speed_gain_q) * closing + 128)
			>>> FRAC_W;
		r    = '0;
		emer = 1'b0;
		if (closing > longint'(deadband_q)) begin
			num  = gap << FRAC_W;
			emer = num < longint'(ttc_lim_q) * closing;
			if (num <= longint'(TTC_MAX_Q8) * closing) begin
				r.ttc_valid = 1'b1;
				r.ttc_value = TTC_W'(num / closing);
			end
		end
		r.emergency = emer;
		if (emer)
			cmd = brake;
		// brake bound first, so the accel bound wins when they cross
		if (cmd < brake)
			cmd = brake;
		if (cmd > longint'(accel_lim_q))
			cmd = longint'(accel_lim_q);
		if (DELAY_TICKS == 0) begin
			delayed = cmd;
		end else begin
			p = (line_pos >= DELAY_TICKS) ? 0 : line_pos;
			delayed = cmd_line[p];
			cmd_line[p] = cmd;
			line_pos = (p + 1 >= DELAY_TICKS) ? 0 : p + 1;
		end
		acc = delayed;
		if (acc < last_accel - longint'(jerk_q))
			acc = last_accel - longint'(jerk_q);
		if (acc > last_accel + longint'(jerk_q))
			acc = last_accel + longint'(jerk_q);
		last_accel  = acc;
		r.accel_out = ACCEL_W'(acc);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   = RST_GAP_SETPOINT;
			gap_gain_q   = RST_GAP_GAIN;
			speed_gain_q = RST_SPEED_GAIN;
			accel_lim_q  = RST_ACCEL_LIMIT;
			brake_lim_q  = RST_BRAKE_LIMIT;
			jerk_q       = RST_JERK_STEP;
			ttc_lim_q    = RST_TTC_LIMIT;
			deadband_q   = RST_DEADBAND;
			foreach (cmd_line[i])
				cmd_line[i] = 0;
			line_pos    = 0;
			last_accel  = 0;
			mismatches  = 0;
			checked     = 0;
			outstanding = 0;
			expected_cmds.delete();
		end else begin
			if (cfg_write === 1'b1) begin
				case (cfg_index)
					CFG_GAP_SETPOINT: setpoint_q   = cfg_data[GAP_W-1:0];
					CFG_GAP_GAIN:     gap_gain_q   = cfg_data[GAIN_W-1:0];
					CFG_SPEED_GAIN:   speed_gain_q = cfg_data[SGAIN_W-1:0];
					CFG_ACCEL_LIMIT:  accel_lim_q  = cfg_data[LIMIT_W-1:0];
					CFG_BRAKE_LIMIT:  brake_lim_q  = cfg_data[ACCEL_W-1:0];
					CFG_JERK_STEP:    jerk_q       = cfg_data[LIMIT_W-1:0];
					CFG_TTC_LIMIT:    ttc_lim_q    = cfg_data[TTC_W-1:0];
					CFG_DEADBAND:     deadband_q   = cfg_data[DEADBAND_W-1:0];
					default: ;
				endcase
			end
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				if (expected_cmds.size() == 0) begin
					flag_mismatch("result word with no tick outstanding");
				end else begin
					want = expected_cmds.pop_front();
					if (result.accel_out !== want.accel_out)
						flag_mismatch($sformatf("accel_out %0d, expected %0d",
							result.accel_out, want.accel_out));
					if (result.ttc_value !== want.ttc_value)
						flag_mismatch($sformatf("ttc_value %0d, expected %0d",
							result.ttc_value, want.ttc_value));
					if (result.ttc_valid !== want.ttc_valid)
						flag_mismatch($sformatf("ttc_valid %b, expected %b",
							result.ttc_valid, want.ttc_valid));
					if (result.emergency !== want.emergency)
						flag_mismatch($sformatf("emergency %b, expected %b",
							result.emergency, want.emergency));
					checked++;
				end
			end
			if (item_valid === 1'b1 && item_stall === 1'b0) begin
				predict_tick(item, fresh);
				expected_cmds.push_back(fresh);
			end
			outstanding = expected_cmds.size();
		end
	end

endmodule

// ===== verif/adaptive_cruise_accel_controller_tb.sv =====
// ----------------------------------------------------------------------------
// adaptive_cruise_accel_controller_tb
// Drives control ticks into the cruise controller under several register
// settings (reset values, range extremes, crossed limits, full-width values
// and random ones), with random idling on both ports and one long output
// hold-off; a side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module adaptive_cruise_accel_controller_tb;
	import acac_pkg::*;

	localparam int DELAY_TICKS    = DELAY_TICKS_DEF;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 64;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	int mismatches;
	int outstanding;
	int checked;

	bit idle_en       = 1'b1;
	bit long_hold_req = 1'b0;
	int words_sent    = 0;
	int settings_cnt  = 1;
	int quiet_cycles  = 0;
	int scen_gap, scen_ego, scen_lead;

	logic [CFG_DATA_W-1:0] reg_img [8];

	always #1 clk = ~clk;

	adaptive_cruise_accel_controller #(
		.DELAY_TICKS(DELAY_TICKS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	accel_command_checker #(
		.DELAY_TICKS(DELAY_TICKS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.checked      (checked)
	);

	// any accepted word on either side resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", quiet_cycles);
				$display("adaptive_cruise_accel_controller_tb NOT OK");
				$finish;
			end
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 13);
				result_stall <= 1'b1;
				repeat (n - 1) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	function automatic item_t mk_word(int gap, int ego, int lead);
		item_t w;
		w.gap_distance = GAP_W'(gap);
		w.ego_speed    = SPEED_W'(ego);
		w.lead_speed   = SPEED_W'(lead);
		return w;
	endfunction

	function automatic int pick_corner(int high, int ones);
		case ($urandom_range(0, 2))
			0: return 0;
			1: return high;
			default: return ones;
		endcase
	endfunction

	function automatic int clip(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// mostly a following scenario that drifts tick by tick, some noise and corners
	function automatic item_t draw_word();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return mk_word($urandom, $urandom, $urandom);
		if (sel == 1)
			return mk_word(pick_corner(51200, 65535), pick_corner(15360, 16383),
				pick_corner(15360, 16383));
		if ($urandom_range(0, 31) == 0 || scen_gap == 0) begin
			scen_gap  = $urandom_range(0, 1) ? $urandom_range(0, 51200)
				: $urandom_range(0, 4000);
			scen_lead = $urandom_range(0, 15360);
			scen_ego  = clip(scen_lead + $urandom_range(0, 1400) - 400, 0, 15360);
		end
		scen_lead = clip(scen_lead + $urandom_range(0, 64) - 32, 0, 15360);
		scen_ego  = clip(scen_ego + $urandom_range(0, 64) - 32, 0, 15360);
		// 0.1 s per tick
		scen_gap  = clip(scen_gap - (scen_ego - scen_lead) / 10, 0, 51200);
		return mk_word(scen_gap, scen_ego, scen_lead);
	endfunction

	task automatic send_word(input item_t w);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		words_sent++;
	endtask

	task automatic send_random(input int n);
		repeat (n) send_word(draw_word());
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic set_image(int sp, int gg, int sg, int al, int bl, int js, int tl, int db);
		reg_img[CFG_GAP_SETPOINT] = CFG_DATA_W'(sp);
		reg_img[CFG_GAP_GAIN]     = CFG_DATA_W'(gg);
		reg_img[CFG_SPEED_GAIN]   = CFG_DATA_W'(sg);
		reg_img[CFG_ACCEL_LIMIT]  = CFG_DATA_W'(al);
		reg_img[CFG_BRAKE_LIMIT]  = CFG_DATA_W'(bl);
		reg_img[CFG_JERK_STEP]    = CFG_DATA_W'(js);
		reg_img[CFG_TTC_LIMIT]    = CFG_DATA_W'(tl);
		reg_img[CFG_DEADBAND]     = CFG_DATA_W'(db);
	endtask

	task automatic random_image();
		set_image($urandom_range(0, 51200), $urandom_range(0, 255), $urandom_range(0, 511),
			$urandom_range(0, 2560), -int'($urandom_range(0, 2560)),
			$urandom_range(0, 2560), $urandom_range(0, 5120), $urandom_range(0, 1280));
		if ($urandom_range(0, 3) == 0)
			reg_img[$urandom_range(0, 7)] = CFG_DATA_W'($urandom);
	endtask

	// only called with the block idle
	task automatic program_regs();
		for (int i = 0; i < $size(reg_img); i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= reg_img[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		settings_cnt++;
	endtask

	initial begin
		scen_gap  = 0;
		scen_ego  = 0;
		scen_lead = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 40 m setpoint, 0.5 m/s deadband, 2 s TTC limit
		send_word(mk_word(0, 0, 0));
		send_word(mk_word(51200, 15360, 0));
		send_word(mk_word(65535, 16383, 16383));
		send_word(mk_word(0, 16383, 0));        // zero gap while closing
		send_word(mk_word(10240, 2176, 2048));  // closing equal to deadband
		send_word(mk_word(1000, 2177, 2048));   // one step above deadband
		send_word(mk_word(51200, 3000, 2744));  // closing, TTC beyond 20 s
		send_word(mk_word(10240, 2560, 2048));  // TTC exactly 20 s
		send_word(mk_word(10241, 2560, 2048));  // just beyond 20 s
		send_word(mk_word(2000, 3000, 2000));   // TTC equal to limit
		send_word(mk_word(1999, 3000, 2000));   // just under limit
		send_word(mk_word(51200, 0, 15360));    // opening fast
		send_word(mk_word(0, 1000, 1000));      // short gap, matched speed
		send_word(mk_word(65535, 0, 16383));
		repeat (3) send_word(mk_word(30000, 5000, 5000));
		drain();

		// crossed limits, frozen jerk, then a wide jerk step
		set_image(10240, 38, 205, 100, 500, 0, 512, 128);
		program_regs();
		send_word(mk_word(0, 16383, 0));
		send_word(mk_word(51200, 0, 15360));
		drain();
		set_image(10240, 38, 205, 100, 500, 4095, 512, 128);
		program_regs();
		repeat (2) send_word(mk_word(0, 1000, 1000));
		send_word(mk_word(51200, 0, 15360));
		drain();

		set_image(51200, 255, 511, 2560, -2560, 2560, 5120, 1280);
		program_regs();
		send_random(120);
		drain();

		set_image(0, 0, 0, 0, 0, 0, 0, 0);
		program_regs();
		send_random(80);
		drain();

		set_image(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
		program_regs();
		send_random(80);
		drain();

		// back to reset values; output held off long enough to back up the input
		set_image(RST_GAP_SETPOINT, RST_GAP_GAIN, RST_SPEED_GAIN, RST_ACCEL_LIMIT,
			RST_BRAKE_LIMIT, RST_JERK_STEP, RST_TTC_LIMIT, RST_DEADBAND);
		program_regs();
		long_hold_req = 1'b1;
		send_random(150);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			idle_en = (ph != 2);
			random_image();
			program_regs();
			send_random(120);
			drain();
		end

		idle_en = 1'b0;
		random_image();
		program_regs();
		send_random(150);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d ticks driven under %0d register settings, %0d results compared",
			words_sent, settings_cnt, checked);
		if (mismatches == 0 && outstanding == 0) begin
			$display("adaptive_cruise_accel_controller_tb OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, outstanding);
			$display("adaptive_cruise_accel_controller_tb NOT OK");
		end
		$finish;
	end

endmodule
